// File: hw/rtl/tlfs_pkg.sv
// Shared types, constants and helper functions of the ticket layout field scanner.
package tlfs_pkg;

    localparam int unsigned WIN_LEN          = 13;
    localparam int unsigned FIRST_FIELD_AT   = 20;
    localparam int unsigned MIN_VALID_SIZE   = 34;
    localparam int unsigned FORMAT_OFFSET    = 8;
    localparam int unsigned LEN_OFFSET       = 9;
    localparam int unsigned VERSION_POS_HI   = 6;
    localparam int unsigned VERSION_POS_LO   = 7;
    localparam int unsigned TYPE_POS_FIRST   = 12;
    localparam int unsigned TYPE_POS_LAST    = 15;
    localparam int unsigned FIRST_TRY_POS    = FIRST_FIELD_AT + WIN_LEN - 1;
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0]  CHAR_ZERO = 8'h30;
    localparam logic [7:0]  CHAR_ONE  = 8'h31;
    localparam logic [7:0]  CHAR_NINE = 8'h39;

    localparam logic [15:0] POS_MAX   = 16'hFFFF;
    localparam logic [12:0] COUNT_MAX = 13'h1FFF;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_SCAN = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    typedef enum logic {
        RK_FIELD   = 1'b0,
        RK_SUMMARY = 1'b1
    } result_kind_t;

    // One queued result: field digits stay raw nibbles until the back end converts them.
    typedef struct packed {
        result_kind_t    kind;
        logic [7:0][3:0] digit;
        logic [7:0]      format;
        logic [15:0]     text_start;
        logic [13:0]     text_length;
        logic            record_valid;
        logic [31:0]     layout_type;
        logic [12:0]     field_count;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    // Two decimal digits, given as the low nibbles of their ASCII codes.
    function automatic logic [6:0] dec_pair(input logic [3:0] hi, input logic [3:0] lo);
        return 7'(hi) * 7'd10 + 7'(lo);
    endfunction

endpackage

// File: hw/rtl/tlfs_front.sv
// Front end: takes record bytes, tracks the parse and judges field headers.
module tlfs_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [15:0]      cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_record,
    input  logic             q_full,
    output logic             q_push,
    output tlfs_pkg::token_t q_token
);
    import tlfs_pkg::*;

    logic [15:0] record_size_reg;
    logic [7:0]  win_reg [WIN_LEN];
    logic [7:0]  win_new [WIN_LEN];
    logic [15:0] pos_reg;
    phase_t      phase_reg, phase_next;
    logic [13:0] skip_reg, skip_next;
    logic        version_ok_reg, version_ok_next;
    logic [31:0] type_reg, type_next;
    logic [12:0] found_reg;

    logic        accept;
    logic        tried;
    logic        digits_ok;
    logic [13:0] text_len;
    logic [16:0] pos_p1;
    logic        fits;
    logic        hdr_valid;
    logic        field_hit;
    logic [4:0]  type_shift;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        for (int i = 0; i < WIN_LEN - 1; i++) begin
            win_new[i] = win_reg[i + 1];
        end
        win_new[WIN_LEN - 1] = s_data_byte;
    end

    always_comb begin
        digits_ok = 1'b1;
        for (int i = 0; i < WIN_LEN; i++) begin
            if (i != FORMAT_OFFSET && !is_digit(win_new[i])) begin
                digits_ok = 1'b0;
            end
        end
    end

    assign text_len = 14'(win_new[LEN_OFFSET][3:0])     * 14'd1000
                    + 14'(win_new[LEN_OFFSET + 1][3:0]) * 14'd100
                    + 14'(win_new[LEN_OFFSET + 2][3:0]) * 14'd10
                    + 14'(win_new[LEN_OFFSET + 3][3:0]);

    // The header starts 12 bytes back, so its text would start at position + 1.
    assign pos_p1    = {1'b0, pos_reg} + 17'd1;
    assign fits      = ({1'b0, record_size_reg} > pos_p1)
                    && ((18'(pos_p1) + 18'(text_len)) <= 18'(record_size_reg));
    assign hdr_valid = digits_ok && fits;
    assign field_hit = tried && hdr_valid && !s_end_of_record;

    // Phase next state.
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HEAD: begin
                if (tried) begin
                    phase_next = hdr_valid ? PH_SCAN : PH_DONE;
                end
            end
            PH_SCAN: begin
                phase_next = PH_SCAN;
            end
            PH_DONE: begin
                phase_next = PH_DONE;
            end
            default: begin
                phase_next = PH_HEAD;
            end
        endcase
    end

    // Phase outputs: when a header is tried and how the skip counter moves.
    always_comb begin
        tried     = 1'b0;
        skip_next = skip_reg;
        unique case (phase_reg)
            PH_HEAD: begin
                tried = (pos_reg == 16'(FIRST_TRY_POS));
            end
            PH_SCAN: begin
                if (skip_reg != '0) begin
                    skip_next = skip_reg - 14'd1;
                end else begin
                    tried = 1'b1;
                end
            end
            PH_DONE: begin
                tried = 1'b0;
            end
            default: begin
                tried = 1'b0;
            end
        endcase
        if (tried && hdr_valid) begin
            skip_next = text_len + 14'(WIN_LEN - 1);
        end
    end

    always_comb begin
        version_ok_next = version_ok_reg;
        if (pos_reg == 16'(VERSION_POS_HI)) begin
            version_ok_next = (s_data_byte == CHAR_ZERO);
        end else if (pos_reg == 16'(VERSION_POS_LO)) begin
            version_ok_next = version_ok_reg && (s_data_byte == CHAR_ONE);
        end
    end

    assign type_shift = {2'(16'(TYPE_POS_LAST) - pos_reg), 3'b000};

    always_comb begin
        type_next = type_reg;
        if (pos_reg >= 16'(TYPE_POS_FIRST) && pos_reg <= 16'(TYPE_POS_LAST)) begin
            type_next = type_reg | (32'(s_data_byte) << type_shift);
        end
    end

    always_comb begin
        q_push  = accept && (s_end_of_record || field_hit);
        q_token = '0;
        if (s_end_of_record) begin
            q_token.kind         = RK_SUMMARY;
            q_token.record_valid = (record_size_reg > 16'(MIN_VALID_SIZE))
                                && version_ok_next
                                && (pos_reg >= 16'(VERSION_POS_LO));
            q_token.layout_type  = type_next;
            q_token.field_count  = found_reg;
        end else begin
            q_token.kind = RK_FIELD;
            for (int i = 0; i < 8; i++) begin
                q_token.digit[i] = win_new[i][3:0];
            end
            q_token.format      = win_new[FORMAT_OFFSET];
            q_token.text_start  = pos_p1[15:0];
            q_token.text_length = text_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            record_size_reg <= '0;
        end else if (cfg_wr_en) begin
            record_size_reg <= cfg_wr_data;
        end
    end

    // The window only feeds header checks, which never look at stale bytes.
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < WIN_LEN; i++) begin
                win_reg[i] <= win_new[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            phase_reg      <= PH_HEAD;
            skip_reg       <= '0;
            version_ok_reg <= 1'b0;
            type_reg       <= '0;
            found_reg      <= '0;
        end else if (accept) begin
            if (s_end_of_record) begin
                pos_reg        <= '0;
                phase_reg      <= PH_HEAD;
                skip_reg       <= '0;
                version_ok_reg <= 1'b0;
                type_reg       <= '0;
                found_reg      <= '0;
            end else begin
                if (pos_reg != POS_MAX) begin
                    pos_reg <= pos_reg + 16'd1;
                end
                phase_reg      <= phase_next;
                skip_reg       <= skip_next;
                version_ok_reg <= version_ok_next;
                type_reg       <= type_next;
                if (field_hit && found_reg != COUNT_MAX) begin
                    found_reg <= found_reg + 13'd1;
                end
            end
        end
    end

    a_eor_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_end_of_record |=> pos_reg == '0 && phase_reg == PH_HEAD)
        else $error("record state not cleared after the final byte");

    a_no_field_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push && q_token.kind == RK_FIELD |-> phase_reg != PH_DONE)
        else $error("field reported after the first header failed");

endmodule

// File: hw/rtl/tlfs_fifo.sv
// Short result queue between the front and back ends.
module tlfs_fifo #(
    parameter int unsigned DEPTH = tlfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tlfs_pkg::token_t push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output tlfs_pkg::token_t head_data
);
    import tlfs_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    token_t             mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into a full result queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from an empty result queue");

endmodule

// File: hw/rtl/tlfs_back.sv
// Back end: decodes queued results into the registered output channel.
module tlfs_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  tlfs_pkg::token_t q_token,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic             m_result_kind,
    output logic [6:0]       m_field_row,
    output logic [6:0]       m_field_column,
    output logic [6:0]       m_field_height,
    output logic [6:0]       m_field_width,
    output logic [7:0]       m_format_byte,
    output logic [15:0]      m_text_start,
    output logic [13:0]      m_text_length,
    output logic             m_record_valid,
    output logic [31:0]      m_layout_type,
    output logic [12:0]      m_field_count
);
    import tlfs_pkg::*;

    logic        out_valid_reg;
    logic        load;
    logic        is_field;

    assign load     = q_valid && (!out_valid_reg || m_ready);
    assign q_pop    = load;
    assign m_valid  = out_valid_reg;
    assign is_field = (q_token.kind == RK_FIELD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_result_kind  <= q_token.kind;
            m_field_row    <= is_field ? dec_pair(q_token.digit[0], q_token.digit[1]) : '0;
            m_field_column <= is_field ? dec_pair(q_token.digit[2], q_token.digit[3]) : '0;
            m_field_height <= is_field ? dec_pair(q_token.digit[4], q_token.digit[5]) : '0;
            m_field_width  <= is_field ? dec_pair(q_token.digit[6], q_token.digit[7]) : '0;
            m_format_byte  <= q_token.format;
            m_text_start   <= q_token.text_start;
            m_text_length  <= q_token.text_length;
            m_record_valid <= q_token.record_valid;
            m_layout_type  <= q_token.layout_type;
            m_field_count  <= q_token.field_count;
        end
    end

endmodule

// File: hw/rtl/ticket_layout_field_scanner.sv
// Top level of the ticket layout field scanner: front end, result queue and back end.
//
//  Channel | Ports                      | Direction | Moves
//  --------+----------------------------+-----------+---------------------------------
//  s_      | s_valid/s_ready + payload  | in        | one record byte per transaction
//  m_      | m_valid/m_ready + payload  | out       | one field or summary per transaction
//  cfg_    | cfg_wr_en, cfg_wr_data     | in        | record_size write, no handshake
//
// The block takes one byte transaction per clock while the result queue is not full.
// The front end judges a complete 13-byte field header in the same cycle the last
// header byte arrives.
// A result reaches the m_ channel through the result queue: the edge that accepts
// the byte that caused it writes the queue, and the output register loads it from
// there once it is empty or m_ready takes its current result.
// Reset (aresetn low at a clock edge) clears the parse state, the queue and the
// output valid; record_size returns to zero.
// The result queue of QUEUE_DEPTH entries lets the input keep flowing while a result
// waits on m_ready; s_ready falls only when the queue is full.
module ticket_layout_field_scanner #(
    parameter int unsigned QUEUE_DEPTH = tlfs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_record,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_result_kind,
    output logic [6:0]  m_field_row,
    output logic [6:0]  m_field_column,
    output logic [6:0]  m_field_height,
    output logic [6:0]  m_field_width,
    output logic [7:0]  m_format_byte,
    output logic [15:0] m_text_start,
    output logic [13:0] m_text_length,
    output logic        m_record_valid,
    output logic [31:0] m_layout_type,
    output logic [12:0] m_field_count
);
    import tlfs_pkg::*;

    // Handshake between the front end and the queue, and the queue and the back end.
    logic   q_full;
    logic   q_push;
    token_t q_push_token;
    logic   q_pop;
    logic   q_head_valid;
    token_t q_head_token;

    // The front end owns record_size and all per-record parse state. It pushes a
    // result only for a valid header or for the final byte of the record.
    tlfs_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_record (s_end_of_record),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_token         (q_push_token)
    );

    // The queue decouples the two halves so each can stall on its own.
    tlfs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (q_push_token),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_token)
    );

    // The back end converts the header digits to binary and holds the result
    // in the output register until the downstream side takes it.
    tlfs_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_head_valid),
        .q_token        (q_head_token),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_kind  (m_result_kind),
        .m_field_row    (m_field_row),
        .m_field_column (m_field_column),
        .m_field_height (m_field_height),
        .m_field_width  (m_field_width),
        .m_format_byte  (m_format_byte),
        .m_text_start   (m_text_start),
        .m_text_length  (m_text_length),
        .m_record_valid (m_record_valid),
        .m_layout_type  (m_layout_type),
        .m_field_count  (m_field_count)
    );

endmodule

// File: sim/tb.sv
// Self-checking testbench for the ticket layout field scanner.
`timescale 1ns / 1ps

module tb;
    import tlfs_pkg::*;

    // One expected transaction on the m_ channel, with each field at its port width.
    typedef struct {
        result_kind_t kind;
        logic [6:0]   row;
        logic [6:0]   column;
        logic [6:0]   height;
        logic [6:0]   width;
        logic [7:0]   format;
        logic [15:0]  text_start;
        logic [13:0]  text_length;
        logic         record_valid;
        logic [31:0]  layout_type;
        logic [12:0]  field_count;
    } scan_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data_byte = '0;
    logic        s_end_of_record = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_result_kind;
    logic [6:0]  m_field_row;
    logic [6:0]  m_field_column;
    logic [6:0]  m_field_height;
    logic [6:0]  m_field_width;
    logic [7:0]  m_format_byte;
    logic [15:0] m_text_start;
    logic [13:0] m_text_length;
    logic        m_record_valid;
    logic [31:0] m_layout_type;
    logic [12:0] m_field_count;

    ticket_layout_field_scanner uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_record (s_end_of_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kind   (m_result_kind),
        .m_field_row     (m_field_row),
        .m_field_column  (m_field_column),
        .m_field_height  (m_field_height),
        .m_field_width   (m_field_width),
        .m_format_byte   (m_format_byte),
        .m_text_start    (m_text_start),
        .m_text_length   (m_text_length),
        .m_record_valid  (m_record_valid),
        .m_layout_type   (m_layout_type),
        .m_field_count   (m_field_count)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Parser state as the scoreboard sees it. It advances once per accepted
    // byte transaction, in the same order the block sees the bytes.
    // ------------------------------------------------------------------
    logic [7:0]   window_bytes [WIN_LEN];
    logic [15:0]  byte_offset;
    phase_t       parse_phase;
    logic [13:0]  text_bytes_left;
    bit           version_seen;
    logic [31:0]  type_word;
    logic [12:0]  fields_seen;
    logic [15:0]  record_size_reg = '0;

    scan_result_t awaited_results [$];
    scan_result_t head_result;
    int unsigned  error_count = 0;

    // Sender and receiver pacing.
    int unsigned  burst_left = 1;
    bit           offering = 1'b0;
    bit           hold_off = 1'b0;
    int unsigned  ready_mode = 0;
    int unsigned  mode_cycles_left = 0;
    event         hold_start;

    function automatic bit ascii_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic logic [7:0] digit_char(input int unsigned n);
        return CHAR_ZERO + 8'(n);
    endfunction

    // Append one byte at the tail of a record under construction.
    function automatic void add_byte(ref logic [7:0] record_bytes [$], input logic [7:0] b);
        record_bytes = {record_bytes, b};
    endfunction

    function automatic int unsigned window_number(input int unsigned from, input int unsigned count);
        int unsigned v;
        v = 0;
        for (int unsigned i = 0; i < count; i++) begin
            v = v * 10 + (int'(window_bytes[from + i]) - int'(CHAR_ZERO));
        end
        return v;
    endfunction

    // A header starting at record offset q is good when it fits inside the record,
    // its digit positions hold ASCII digits and its text also fits.
    function automatic bit header_fits(input int unsigned q, output int unsigned len);
        int unsigned room;
        len = 0;
        if (record_size_reg <= q) return 1'b0;
        room = record_size_reg - q;
        if (room <= WIN_LEN) return 1'b0;
        for (int unsigned i = 0; i < WIN_LEN; i++) begin
            if (i != FORMAT_OFFSET && !ascii_digit(window_bytes[i])) return 1'b0;
        end
        len = window_number(LEN_OFFSET, 4);
        return len + WIN_LEN <= room;
    endfunction

    function automatic void clear_record_state();
        foreach (window_bytes[i]) window_bytes[i] = '0;
        byte_offset = '0;
        parse_phase = PH_HEAD;
        text_bytes_left = '0;
        version_seen = 1'b0;
        type_word = '0;
        fields_seen = '0;
    endfunction

    // Advance the parser by one byte and queue whatever result the byte causes.
    function automatic void parse_byte(input logic [7:0] b, input logic eor);
        int unsigned p;
        int unsigned q;
        int unsigned len;
        bit tried;
        bit good;
        scan_result_t r;
        p = byte_offset;
        q = 0;
        len = 0;
        tried = 1'b0;
        good = 1'b0;
        for (int unsigned i = 0; i < WIN_LEN - 1; i++) window_bytes[i] = window_bytes[i + 1];
        window_bytes[WIN_LEN - 1] = b;

        if (p == VERSION_POS_HI) begin
            version_seen = (b == CHAR_ZERO);
        end else if (p == VERSION_POS_LO) begin
            version_seen = version_seen && (b == CHAR_ONE);
        end
        if (p >= TYPE_POS_FIRST && p <= TYPE_POS_LAST) begin
            type_word |= 32'(b) << ((TYPE_POS_LAST - p) * 8);
        end

        // The first header is tried exactly once; after a good field the text is
        // skipped and then every byte closes a candidate header.
        if (parse_phase == PH_HEAD) begin
            tried = (p == FIRST_TRY_POS);
        end else if (parse_phase == PH_SCAN) begin
            if (text_bytes_left != 0) begin
                text_bytes_left--;
            end else begin
                tried = 1'b1;
            end
        end
        if (tried) begin
            q = p - (WIN_LEN - 1);
            good = header_fits(q, len);
        end

        r = '{kind: RK_FIELD, default: '0};
        if (eor) begin
            // The final byte always yields the summary, even if it completes a header.
            r.kind = RK_SUMMARY;
            r.record_valid = record_size_reg > MIN_VALID_SIZE && version_seen
                             && p >= VERSION_POS_LO;
            r.layout_type = type_word;
            r.field_count = fields_seen;
            awaited_results = {awaited_results, r};
            clear_record_state();
            return;
        end

        if (byte_offset != POS_MAX) byte_offset++;

        if (good) begin
            r.row = 7'(window_number(0, 2));
            r.column = 7'(window_number(2, 2));
            r.height = 7'(window_number(4, 2));
            r.width = 7'(window_number(6, 2));
            r.format = window_bytes[FORMAT_OFFSET];
            r.text_start = 16'(q + WIN_LEN);
            r.text_length = 14'(len);
            if (fields_seen != COUNT_MAX) fields_seen++;
            text_bytes_left = 14'(len + WIN_LEN - 1);
            parse_phase = PH_SCAN;
            awaited_results = {awaited_results, r};
        end else if (tried && parse_phase == PH_HEAD) begin
            parse_phase = PH_DONE;
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checking and receiver pacing. m_ready is sampled here before the
    // update of this edge lands, so the check sees the handshake that happened.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: result_kind mismatch, expected none, actual %0d",
                         $time, m_result_kind);
                error_count++;
            end else begin
                head_result = awaited_results.pop_front();
                check_field("result_kind", head_result.kind, m_result_kind);
                check_field("field_row", head_result.row, m_field_row);
                check_field("field_column", head_result.column, m_field_column);
                check_field("field_height", head_result.height, m_field_height);
                check_field("field_width", head_result.width, m_field_width);
                check_field("format_byte", head_result.format, m_format_byte);
                check_field("text_start", head_result.text_start, m_text_start);
                check_field("text_length", head_result.text_length, m_text_length);
                check_field("record_valid", head_result.record_valid, m_record_valid);
                check_field("layout_type", head_result.layout_type, m_layout_type);
                check_field("field_count", head_result.field_count, m_field_count);
            end
        end

        // The receiver switches between random stall patterns, including stretches
        // where it never stalls at all.
        if (mode_cycles_left == 0) begin
            ready_mode = $urandom_range(0, 3);
            mode_cycles_left = $urandom_range(64, 256);
        end else begin
            mode_cycles_left--;
        end
        if (hold_off) begin
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ($urandom_range(0, 1) != 0);
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // A long receiver hold-off, counted here so the sender keeps offering
    // transactions while the result queue fills and s_ready drops.
    always begin
        @(hold_start);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Sending side.
    // ------------------------------------------------------------------

    // Offer one byte and hold it until the block takes it. Bursts end with a gap
    // so valid is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] d, input logic eor);
        s_valid <= 1'b1;
        s_data_byte <= d;
        s_end_of_record <= eor;
        offering = 1'b1;
        do @(posedge aclk); while (!s_ready);
        parse_byte(d, eor);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            offering = 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                      : $urandom_range(1, 12);
        end
    endtask

    task automatic send_record(ref logic [7:0] record_bytes [$]);
        foreach (record_bytes[i]) begin
            send_byte(record_bytes[i], i == record_bytes.size() - 1);
        end
    endtask

    // Let every expected transaction drain, then allow for a byte still in flight
    // that caused no result.
    task automatic wait_idle();
        if (offering) begin
            s_valid <= 1'b0;
            offering = 1'b0;
        end
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_record_size(input logic [15:0] value);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        record_size_reg = value;
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Record builders.
    // ------------------------------------------------------------------
    task automatic append_record_header(ref logic [7:0] record_bytes [$], input bit good_version);
        logic [7:0] b;
        for (int i = 0; i < FIRST_FIELD_AT; i++) begin
            b = 8'($urandom);
            if (good_version && i == VERSION_POS_HI) b = CHAR_ZERO;
            if (good_version && i == VERSION_POS_LO) b = CHAR_ONE;
            add_byte(record_bytes, b);
        end
    endtask

    task automatic append_field(ref logic [7:0] record_bytes [$],
                                input int unsigned row, input int unsigned column,
                                input int unsigned height, input int unsigned width,
                                input logic [7:0] format, input int unsigned len);
        add_byte(record_bytes, digit_char(row / 10));
        add_byte(record_bytes, digit_char(row % 10));
        add_byte(record_bytes, digit_char(column / 10));
        add_byte(record_bytes, digit_char(column % 10));
        add_byte(record_bytes, digit_char(height / 10));
        add_byte(record_bytes, digit_char(height % 10));
        add_byte(record_bytes, digit_char(width / 10));
        add_byte(record_bytes, digit_char(width % 10));
        add_byte(record_bytes, format);
        add_byte(record_bytes, digit_char(len / 1000));
        add_byte(record_bytes, digit_char((len / 100) % 10));
        add_byte(record_bytes, digit_char((len / 10) % 10));
        add_byte(record_bytes, digit_char(len % 10));
        repeat (len) add_byte(record_bytes, 8'($urandom));
    endtask

    // A field with random content; a broken one has a single digit position
    // replaced by a character just outside the digit range or far from it.
    task automatic append_random_field(ref logic [7:0] record_bytes [$], input bit broken,
                                       input int unsigned max_len);
        int unsigned len;
        int unsigned spot;
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 120) : $urandom_range(0, max_len);
        append_field(record_bytes, $urandom_range(0, 99), $urandom_range(0, 99),
                     $urandom_range(0, 99), $urandom_range(0, 99), 8'($urandom), len);
        if (broken) begin
            spot = $urandom_range(0, WIN_LEN - 2);
            if (spot >= FORMAT_OFFSET) spot++;
            spot += record_bytes.size() - len - WIN_LEN;
            case ($urandom_range(0, 2))
                0: record_bytes[spot] = CHAR_ZERO - 8'd1;
                1: record_bytes[spot] = CHAR_NINE + 8'd1;
                default: record_bytes[spot] = 8'($urandom_range(CHAR_NINE + 1, 255));
            endcase
        end
    endtask

    // Filler between fields: digits, near-miss characters and arbitrary bytes, so
    // that false headers and resynchronisation both show up.
    task automatic append_noise(ref logic [7:0] record_bytes [$], input int unsigned count);
        repeat (count) begin
            case ($urandom_range(0, 3))
                0: add_byte(record_bytes, digit_char($urandom_range(0, 9)));
                1: add_byte(record_bytes, ($urandom_range(0, 1) != 0) ? CHAR_ZERO - 8'd1
                                                                      : CHAR_NINE + 8'd1);
                default: add_byte(record_bytes, 8'($urandom));
            endcase
        end
    endtask

    // Mostly well-formed records of the configured size, with broken headers,
    // noise, early ends and overlong records mixed in.
    task automatic build_random_record(ref logic [7:0] record_bytes [$],
                                       input int unsigned size, input int unsigned max_len);
        int unsigned target;
        case ($urandom_range(0, 9))
            0: target = $urandom_range(1, 40);
            1: target = size + $urandom_range(1, 20);
            default: target = (size == 0) ? $urandom_range(1, 40) : size;
        endcase
        append_record_header(record_bytes, $urandom_range(0, 4) != 0);
        append_random_field(record_bytes, $urandom_range(0, 9) == 0, max_len);
        while (record_bytes.size() < target) begin
            case ($urandom_range(0, 5))
                0: append_noise(record_bytes, $urandom_range(1, 6));
                1: append_random_field(record_bytes, 1'b1, max_len);
                default: append_random_field(record_bytes, 1'b0, max_len);
            endcase
        end
        while (record_bytes.size() > target) void'(record_bytes.pop_back());
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Records that end inside the record header: eight bytes at record_size zero, a lone
    // final byte, a version cut after its first byte, and a layout type cut after two of its four bytes.
    task automatic test_short_records();
        logic [7:0] record_bytes [$];
        write_record_size(16'd0);
        append_record_header(record_bytes, 1'b1);
        while (record_bytes.size() > 8) void'(record_bytes.pop_back());
        send_record(record_bytes);
        write_record_size(16'd100);
        record_bytes = '{8'hFF};
        send_record(record_bytes);
        record_bytes.delete();
        append_record_header(record_bytes, 1'b1);
        while (record_bytes.size() > VERSION_POS_LO) void'(record_bytes.pop_back());
        send_record(record_bytes);
        record_bytes.delete();
        append_record_header(record_bytes, 1'b1);
        while (record_bytes.size() > TYPE_POS_FIRST + 2) void'(record_bytes.pop_back());
        send_record(record_bytes);
    endtask

    // The smallest record that is valid and holds a field, then one byte less,
    // where the field still fits but the record no longer counts as valid.
    task automatic test_minimum_field();
        logic [7:0] record_bytes [$];
        write_record_size(MIN_VALID_SIZE + 1);
        append_record_header(record_bytes, 1'b1);
        append_field(record_bytes, 99, 0, 0, 99, 8'hFF, 2);
        send_record(record_bytes);
        write_record_size(MIN_VALID_SIZE);
        record_bytes.delete();
        append_record_header(record_bytes, 1'b1);
        append_field(record_bytes, 0, 99, 99, 0, 8'h00, 1);
        send_record(record_bytes);
    endtask

    // A bad header at byte 20 means no fields at all, even with a good one behind it.
    task automatic test_invalid_first_header();
        logic [7:0] record_bytes [$];
        write_record_size(16'd80);
        append_record_header(record_bytes, 1'b1);
        append_random_field(record_bytes, 1'b1, 4);
        append_noise(record_bytes, 1);
        append_field(record_bytes, 12, 34, 56, 78, 8'h41, 3);
        if (record_bytes.size() < 80) append_noise(record_bytes, 80 - record_bytes.size());
        send_record(record_bytes);
    endtask

    // A good header that completes on the final byte is dropped in favor of the summary.
    task automatic test_header_on_final_byte();
        logic [7:0] record_bytes [$];
        write_record_size(16'd100);
        append_record_header(record_bytes, 1'b1);
        append_field(record_bytes, 1, 2, 3, 4, 8'h55, 3);
        append_field(record_bytes, 5, 6, 7, 8, 8'hAA, 2);
        void'(record_bytes.pop_back());
        void'(record_bytes.pop_back());
        send_record(record_bytes);
    endtask

    // Bytes beyond record_size are taken, but no header judged there is good.
    task automatic test_bytes_past_size();
        logic [7:0] record_bytes [$];
        write_record_size(16'd40);
        append_record_header(record_bytes, 1'b1);
        while (record_bytes.size() < 90) append_field(record_bytes, 10, 20, 30, 40, 8'h7E, 0);
        send_record(record_bytes);
    endtask

    // Back-to-back fields with empty text, then the longest text length in a
    // record that ends early, so the text itself is never sent.
    task automatic test_text_length_extremes();
        logic [7:0] record_bytes [$];
        write_record_size(16'hFFFF);
        append_record_header(record_bytes, 1'b1);
        repeat (3) append_field(record_bytes, 0, 0, 0, 0, 8'h01, 0);
        append_noise(record_bytes, 5);
        send_record(record_bytes);
        record_bytes.delete();
        append_record_header(record_bytes, 1'b1);
        append_field(record_bytes, 99, 99, 99, 99, 8'h80, 0);
        for (int i = 1; i <= 4; i++) record_bytes[record_bytes.size() - i] = digit_char(9);
        append_noise(record_bytes, 20);
        send_record(record_bytes);
    endtask

    // The receiver holds off for a long stretch while many short fields arrive,
    // so the result queue fills and the block stops taking bytes.
    task automatic test_backpressure();
        logic [7:0] record_bytes [$];
        write_record_size(16'd400);
        append_record_header(record_bytes, 1'b1);
        repeat (24) append_field(record_bytes, $urandom_range(0, 99), $urandom_range(0, 99),
                                 $urandom_range(0, 99), $urandom_range(0, 99),
                                 8'($urandom), 0);
        -> hold_start;
        send_record(record_bytes);
    endtask

    task automatic test_random_records();
        logic [7:0] record_bytes [$];
        int unsigned bytes_sent;
        int unsigned size;
        bytes_sent = 0;
        while (bytes_sent < 900) begin
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MIN_VALID_SIZE)
                                               : $urandom_range(MIN_VALID_SIZE + 1, 160);
            write_record_size(16'(size));
            repeat (2) begin
                record_bytes.delete();
                build_random_record(record_bytes, size, 15);
                send_record(record_bytes);
                bytes_sent += record_bytes.size();
            end
        end
    endtask

    initial begin
        clear_record_state();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_short_records();
        test_minimum_field();
        test_invalid_first_header();
        test_header_on_final_byte();
        test_bytes_past_size();
        test_text_length_extremes();
        test_backpressure();
        test_random_records();

        wait_idle();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #500000;
        $display("tb: failure");
        $finish;
    end

endmodule
